FILE: hdl/dlle_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Doubly linked list engine package
// Shared widths, command and status codes, and the sequencer state type.
// -----------------------------------------------------------------------------
package dlle_pkg;

	localparam int DEF_CAPACITY = 32;
	localparam int VALUE_W      = 32;
	localparam int POS_W        = 16;
	localparam int CMD_W        = 3;
	localparam int ST_W         = 3;

	localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

	localparam logic [ST_W-1:0] ST_OK        = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
	localparam logic [ST_W-1:0] ST_INVALID   = 3'd2;
	localparam logic [ST_W-1:0] ST_OOB       = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY     = 3'd5;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INS_WR,
		S_FIX,
		S_WALK_POS,
		S_WALK_DEL,
		S_DEL_P,
		S_DEL_Q,
		S_RO_FWD,
		S_RO_BWD,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		M_HEAD,
		M_TAIL,
		M_MID
	} ins_mode_t;

endpackage
`default_nettype wire

FILE: hdl/doubly_linked_list_engine_core.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Doubly linked list engine
// Keeps an ordered list of signed values in a pool of linked nodes held in RAM.
// -----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       sink       in_valid / in_stall   cmd, value, position
//  out      source     out_valid / out_stall status, item_value, direction, last
//
//  Head and tail inserts write the node, then fix any neighbour; an insert
//  at a position walks to it first, a delete to the first node holding the
//  value. A read-out gives one item a cycle from the node RAM unless the
//  output stalls. The walk is bound by the single read port of the node
//  RAM. Reset empties the list at once. A stalled output holds the sequencer.
// -----------------------------------------------------------------------------
module doubly_linked_list_engine_core #(
	parameter int CAPACITY = dlle_pkg::DEF_CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [dlle_pkg::CMD_W-1:0]        cmd,
	input  wire logic signed [dlle_pkg::VALUE_W-1:0] value,
	input  wire logic signed [dlle_pkg::POS_W-1:0] position,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [dlle_pkg::ST_W-1:0]              status,
	output logic signed [dlle_pkg::VALUE_W-1:0]    item_value,
	output logic                                   direction,
	output logic                                   last
);
	import dlle_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int EW = VALUE_W + 2 * LW;
	localparam logic [LW-1:0] NIL = LW'(CAPACITY);
	localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

	state_t state_q, state_d;
	ins_mode_t mode_q, mode_d;
	logic [CAPACITY-1:0] used_q, used_d;
	logic [LW-1:0] head_q, head_d, tail_q, tail_d, count_q, count_d;
	logic [LW-1:0] cur_q, cur_d, aft_q, aft_d, step_q, step_d, tgt_q, tgt_d;
	logic [LW-1:0] fix_addr_q, fix_addr_d, link_q, link_d;
	logic fix_prev_q, fix_prev_d;
	logic [ST_W-1:0] st_q, st_d;
	logic [VALUE_W-1:0] val_q, val_d;

	logic out_valid_q;
	logic [ST_W-1:0] out_st_q;
	logic [VALUE_W-1:0] out_val_q;
	logic out_dir_q, out_last_q;
	logic out_ld;
	logic [ST_W-1:0] ld_st;
	logic [VALUE_W-1:0] ld_val;
	logic ld_dir, ld_last;

	logic we, re;
	logic [LW-1:0] wlink, rlink;
	logic [EW-1:0] wdata, rdata;
	logic [VALUE_W-1:0] rd_val;
	logic [LW-1:0] rd_prev, rd_next, free_idx;
	logic signed [POS_W-1:0] cnt1;

	dlle_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_nodes (
		.clk  (clk),
		.we   (we),
		.waddr(wlink[AW-1:0]),
		.wdata(wdata),
		.re   (re),
		.raddr(rlink[AW-1:0]),
		.rdata(rdata)
	);

	assign rd_val  = rdata[EW-1 -: VALUE_W];
	assign rd_prev = rdata[2*LW-1:LW];
	assign rd_next = rdata[LW-1:0];
	assign cnt1    = $signed(POS_W'(count_q) + POS_W'(1));
	assign out_ld  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		free_idx = NIL;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = LW'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			head_q      <= NIL;
			tail_q      <= NIL;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
			if (out_ld) begin
				out_valid_q <= (ld_st != ST_OK) || ld_dir || ld_last || state_q == S_RO_FWD
					? (state_q == S_EMIT || state_q == S_RO_FWD || state_q == S_RO_BWD)
					: 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mode_q     <= mode_d;
		cur_q      <= cur_d;
		aft_q      <= aft_d;
		step_q     <= step_d;
		tgt_q      <= tgt_d;
		fix_addr_q <= fix_addr_d;
		fix_prev_q <= fix_prev_d;
		link_q     <= link_d;
		st_q       <= st_d;
		val_q      <= val_d;
		if (out_ld) begin
			out_st_q   <= ld_st;
			out_val_q  <= ld_val;
			out_dir_q  <= ld_dir;
			out_last_q <= ld_last;
		end
	end

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		used_d     = used_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		cur_d      = cur_q;
		aft_d      = aft_q;
		step_d     = step_q;
		tgt_d      = tgt_q;
		fix_addr_d = fix_addr_q;
		fix_prev_d = fix_prev_q;
		link_d     = link_q;
		st_d       = st_q;
		val_d      = val_q;
		we         = 1'b0;
		wlink      = cur_q;
		wdata      = rdata;
		re         = 1'b0;
		rlink      = head_q;
		ld_st      = ST_OK;
		ld_val     = rd_val;
		ld_dir     = 1'b0;
		ld_last    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					val_d = value;
					st_d  = ST_OK;
					case (cmd)
						CMD_INS_HEAD, CMD_INS_TAIL: begin
							if (count_q == CAP_L) begin
								st_d    = ST_FULL;
								state_d = S_EMIT;
							end else begin
								mode_d  = (cmd == CMD_INS_HEAD) ? M_HEAD : M_TAIL;
								rlink   = (cmd == CMD_INS_HEAD) ? head_q : tail_q;
								re      = (rlink != NIL);
								state_d = S_INS_WR;
							end
						end
						CMD_INS_POS: begin
							if (position < 1) begin
								st_d    = ST_INVALID;
								state_d = S_EMIT;
							end else if (count_q == CAP_L) begin
								st_d    = ST_FULL;
								state_d = S_EMIT;
							end else if (position == 1) begin
								mode_d  = M_HEAD;
								rlink   = head_q;
								re      = (head_q != NIL);
								state_d = S_INS_WR;
							end else if (position > cnt1) begin
								st_d    = ST_OOB;
								state_d = S_EMIT;
							end else if (position == cnt1) begin
								mode_d  = M_TAIL;
								rlink   = tail_q;
								re      = (tail_q != NIL);
								state_d = S_INS_WR;
							end else begin
								mode_d  = M_MID;
								cur_d   = head_q;
								step_d  = LW'(1);
								tgt_d   = LW'(position - POS_W'(1));
								rlink   = head_q;
								re      = 1'b1;
								state_d = S_WALK_POS;
							end
						end
						CMD_DELETE: begin
							if (head_q == NIL) begin
								st_d    = ST_EMPTY;
								state_d = S_EMIT;
							end else begin
								cur_d   = head_q;
								rlink   = head_q;
								re      = 1'b1;
								state_d = S_WALK_DEL;
							end
						end
						CMD_READ: begin
							if (head_q == NIL) begin
								st_d    = ST_EMPTY;
								val_d   = '0;
								state_d = S_EMIT;
							end else begin
								rlink   = head_q;
								re      = 1'b1;
								state_d = S_RO_FWD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_INS_WR: begin
				we = 1'b1;
				wlink = free_idx;
				used_d[free_idx[AW-1:0]] = 1'b1;
				count_d = count_q + LW'(1);
				link_d = free_idx;
				state_d = S_EMIT;
				case (mode_q)
					M_HEAD: begin
						wdata = {val_q, NIL, head_q};
						head_d = free_idx;
						fix_addr_d = head_q;
						fix_prev_d = 1'b1;
						if (head_q == NIL) begin
							tail_d = free_idx;
						end else begin
							state_d = S_FIX;
						end
					end
					M_TAIL: begin
						wdata = {val_q, tail_q, NIL};
						tail_d = free_idx;
						fix_addr_d = tail_q;
						fix_prev_d = 1'b0;
						if (tail_q == NIL) begin
							head_d = free_idx;
						end else begin
							state_d = S_FIX;
						end
					end
					default: begin
						wdata = {val_q, cur_q, aft_q};
						fix_addr_d = aft_q;
						fix_prev_d = 1'b1;
						if (aft_q == NIL) begin
							tail_d = free_idx;
						end else begin
							state_d = S_FIX;
						end
					end
				endcase
			end
			S_FIX: begin
				we = 1'b1;
				wlink = fix_addr_q;
				wdata = fix_prev_q ? {rd_val, link_q, rd_next} : {rd_val, rd_prev, link_q};
				state_d = S_EMIT;
			end
			S_WALK_POS: begin
				if (step_q == tgt_q) begin
					we = 1'b1;
					wlink = cur_q;
					wdata = {rd_val, rd_prev, free_idx};
					aft_d = rd_next;
					rlink = rd_next;
					re = (rd_next != NIL);
					state_d = S_INS_WR;
				end else begin
					cur_d = rd_next;
					rlink = rd_next;
					re = 1'b1;
					step_d = step_q + LW'(1);
				end
			end
			S_WALK_DEL: begin
				if (rd_val == val_q) begin
					used_d[cur_q[AW-1:0]] = 1'b0;
					count_d = count_q - LW'(1);
					cur_d = rd_prev;
					aft_d = rd_next;
					if (rd_prev != NIL) begin
						rlink = rd_prev;
						re = 1'b1;
						state_d = S_DEL_P;
					end else begin
						head_d = rd_next;
						if (rd_next != NIL) begin
							rlink = rd_next;
							re = 1'b1;
							state_d = S_DEL_Q;
						end else begin
							tail_d = rd_prev;
							state_d = S_EMIT;
						end
					end
				end else if (rd_next == NIL) begin
					st_d = ST_NOT_FOUND;
					state_d = S_EMIT;
				end else begin
					cur_d = rd_next;
					rlink = rd_next;
					re = 1'b1;
				end
			end
			S_DEL_P: begin
				we = 1'b1;
				wlink = cur_q;
				wdata = {rd_val, rd_prev, aft_q};
				if (aft_q != NIL) begin
					rlink = aft_q;
					re = 1'b1;
					state_d = S_DEL_Q;
				end else begin
					tail_d = cur_q;
					state_d = S_EMIT;
				end
			end
			S_DEL_Q: begin
				we = 1'b1;
				wlink = aft_q;
				wdata = {rd_val, cur_q, rd_next};
				state_d = S_EMIT;
			end
			S_RO_FWD: begin
				if (out_ld) begin
					re = 1'b1;
					if (rd_next != NIL) begin
						rlink = rd_next;
					end else begin
						rlink = tail_q;
						state_d = S_RO_BWD;
					end
				end
			end
			S_RO_BWD: begin
				ld_dir = 1'b1;
				ld_last = (rd_prev == NIL);
				if (out_ld) begin
					if (rd_prev != NIL) begin
						rlink = rd_prev;
						re = 1'b1;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_EMIT: begin
				ld_st = st_q;
				ld_val = val_q;
				ld_last = 1'b1;
				if (out_ld) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign status     = out_st_q;
	assign item_value = out_val_q;
	assign direction  = out_dir_q;
	assign last       = out_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_L)
		else $error("entry count exceeds capacity");

	a_count_used: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("entry count disagrees with used nodes");

	a_head_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == NIL) == (count_q == '0))
		else $error("head pointer disagrees with entry count");

	a_tail_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(tail_q == NIL) == (head_q == NIL))
		else $error("head and tail disagree on an empty list");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !we)
		else $error("node RAM written while idle");

endmodule
`default_nettype wire

FILE: hdl/dlle_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// -----------------------------------------------------------------------------
module dlle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire
